@@ sv/char_lcd_controller_emulator_assert.svh @@
// Assertion macros shared by the character display controller RTL.
// Each macro takes a label, a clock, an active-low reset, a condition and
// the property that must follow from it.
`ifndef CHAR_LCD_CONTROLLER_EMULATOR_ASSERT_SVH
`define CHAR_LCD_CONTROLLER_EMULATOR_ASSERT_SVH

// Same-cycle implication.
`define CLCE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("char_lcd_controller_emulator: assertion failed");

// Next-cycle implication.
`define CLCE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("char_lcd_controller_emulator: assertion failed");

`endif

@@ sv/clce_pkg.sv @@
`timescale 1ns / 1ps

package clce_pkg;

    // Display geometry
    localparam int ROWS  = 4;
    localparam int COLS  = 20;
    localparam int CELLS = ROWS * COLS;
    localparam int IDX_W = $clog2(CELLS);

    localparam logic [1:0] ROW_MAX = 2'(ROWS - 1);
    localparam logic [4:0] COL_MAX = 5'(COLS - 1);

    // Item operations
    localparam logic [1:0] OP_WRITE  = 2'd0;
    localparam logic [1:0] OP_STATUS = 2'd1;
    localparam logic [1:0] OP_CELL   = 2'd2;

    // Control bytes of a pair
    localparam logic [7:0] CTL_CMD  = 8'h80;
    localparam logic [7:0] CTL_DATA = 8'h40;

    // Command codes
    localparam logic [7:0] CMD_CLEAR     = 8'h01;
    localparam logic [7:0] CMD_HOME      = 8'h02;
    localparam logic [7:0] CMD_CTRL_MASK = 8'hF8;
    localparam logic [7:0] CMD_CTRL_VAL  = 8'h08;

    // Character range
    localparam logic [7:0] CHAR_MIN   = 8'h20;
    localparam logic [7:0] CHAR_MAX   = 8'h7E;
    localparam logic [6:0] CHAR_SPACE = 7'h20;

    typedef struct packed {
        logic [6:0] read_data;
        logic [1:0] row_now;
        logic [4:0] col_now;
        logic       display_enabled;
        logic       cursor_shown;
        logic       blink_enabled;
        logic       bad_control;
    } t_res;

endpackage

@@ sv/clce_if.sv @@
`timescale 1ns / 1ps

interface clce_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic [7:0] pair_ctl;
    logic [7:0] pair_arg;
    logic [1:0] cell_row;
    logic [4:0] cell_col;

    modport source (
        output valid, op, pair_ctl, pair_arg, cell_row, cell_col,
        input  ready
    );
    modport sink (
        input  valid, op, pair_ctl, pair_arg, cell_row, cell_col,
        output ready
    );
endinterface

interface clce_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] read_data;
    logic [1:0] row_now;
    logic [4:0] col_now;
    logic       display_enabled;
    logic       cursor_shown;
    logic       blink_enabled;
    logic       bad_control;

    modport source (
        output valid, read_data, row_now, col_now, display_enabled,
               cursor_shown, blink_enabled, bad_control,
        input  ready
    );
    modport sink (
        input  valid, read_data, row_now, col_now, display_enabled,
               cursor_shown, blink_enabled, bad_control,
        output ready
    );
endinterface

@@ sv/char_lcd_controller_emulator.sv @@
// Character display controller, 20 columns by 4 rows. Each input transfer is
// a control/data byte pair write (control 0x80 runs a command: clear, home,
// set address, display/cursor/blink control; control 0x40 stores a character
// at the cursor and advances it, wrapping across rows; any other control byte
// is flagged in bad_control and changes nothing), a status read that returns
// the display address, or a cell read that returns the stored character.
// Every input transfer produces exactly one output transfer carrying the
// read data, the cursor after the item and the three display flags. One item
// is taken every clock cycle while the output side does not stall; its
// result is registered in stage A at the accepting edge and then moves to
// stage B before it is offered at the output: one register stage for the
// registered read port of the 80-entry character memory and one for the
// output register. All state updates land at the accepting edge, so the next
// item sees them at once. After reset every cell reads as a space: a valid
// bit per cell marks written entries, and the clear command drops all valid
// bits together at its accepting edge, so no clearing pass is needed.
`timescale 1ns / 1ps
`include "char_lcd_controller_emulator_assert.svh"

module char_lcd_controller_emulator import clce_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    clce_in_if.sink    i_in,
    clce_out_if.source o_out
);

    // Architectural state
    logic [1:0]       r_row, n_row;
    logic [4:0]       r_col, n_col;
    logic [6:0]       r_addr, n_addr;
    logic             r_disp, n_disp;
    logic             r_curs, n_curs;
    logic             r_blnk, n_blnk;
    logic [CELLS-1:0] r_cell_vld, n_cell_vld;

    // Character memory
    logic [6:0]       r_mem [CELLS];
    logic [6:0]       r_mem_q;

    // Stage A: state updated, memory read in flight
    logic             r_a_valid;
    t_res             r_a_res;
    logic             r_a_cell;
    logic             r_a_cell_vld;

    // Stage B: output register
    logic             r_b_valid;
    t_res             r_b_res;

    logic             acc;
    logic             a_move;
    logic             wr_en;
    logic             bad;
    logic [6:0]       wr_ch;
    logic [6:0]       rd_status;
    logic [IDX_W-1:0] wr_idx;
    logic [IDX_W-1:0] rd_idx;
    t_res             a_merged;

    // Handshake: stage A drains into B whenever B is empty or being taken.
    assign a_move     = r_a_valid && (!r_b_valid || o_out.ready);
    assign i_in.ready = !r_a_valid || a_move;
    assign acc        = i_in.valid && i_in.ready;

    // Cell addressing: row-major, COLS entries per row.
    assign wr_idx = IDX_W'(r_row) * IDX_W'(COLS) + IDX_W'(r_col);
    assign rd_idx = IDX_W'(i_in.cell_row) * IDX_W'(COLS) + IDX_W'(i_in.cell_col);

    // Store printable ASCII as given, anything else as a space.
    assign wr_ch = (i_in.pair_arg >= CHAR_MIN && i_in.pair_arg <= CHAR_MAX)
                 ? i_in.pair_arg[6:0] : CHAR_SPACE;

    assign rd_status = (i_in.op == OP_STATUS) ? r_addr : 7'd0;

    // Next state for one item
    always_comb begin
        n_row      = r_row;
        n_col      = r_col;
        n_addr     = r_addr;
        n_disp     = r_disp;
        n_curs     = r_curs;
        n_blnk     = r_blnk;
        n_cell_vld = r_cell_vld;
        wr_en      = 1'b0;
        bad        = 1'b0;
        case (i_in.op)
            OP_WRITE: begin
                if (i_in.pair_ctl == CTL_CMD) begin
                    if (i_in.pair_arg == CMD_CLEAR) begin
                        n_cell_vld = '0;
                        n_row      = 2'd0;
                        n_col      = 5'd0;
                        n_addr     = 7'd0;
                    end else if (i_in.pair_arg == CMD_HOME) begin
                        n_row  = 2'd0;
                        n_col  = 5'd0;
                        n_addr = 7'd0;
                    end else if (i_in.pair_arg[7]) begin
                        // Keep the raw address; clamp the cursor into the grid.
                        n_addr = i_in.pair_arg[6:0];
                        n_row  = (i_in.pair_arg[6:5] > ROW_MAX) ? ROW_MAX
                                                                : i_in.pair_arg[6:5];
                        n_col  = (i_in.pair_arg[4:0] > COL_MAX) ? COL_MAX
                                                                : i_in.pair_arg[4:0];
                    end else if ((i_in.pair_arg & CMD_CTRL_MASK) == CMD_CTRL_VAL) begin
                        n_disp = i_in.pair_arg[2];
                        n_curs = i_in.pair_arg[1];
                        n_blnk = i_in.pair_arg[0];
                    end
                end else if (i_in.pair_ctl == CTL_DATA) begin
                    if (r_row <= ROW_MAX && r_col <= COL_MAX) begin
                        wr_en              = 1'b1;
                        n_cell_vld[wr_idx] = 1'b1;
                        // Advance the cursor, wrap at the end of a row and screen.
                        if (r_col == COL_MAX) begin
                            n_col = 5'd0;
                            n_row = (r_row == ROW_MAX) ? 2'd0 : r_row + 2'd1;
                        end else begin
                            n_col = r_col + 5'd1;
                        end
                        n_addr = {n_row, n_col};
                    end
                end else begin
                    bad = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row      <= 2'd0;
            r_col      <= 5'd0;
            r_addr     <= 7'd0;
            r_disp     <= 1'b1;
            r_curs     <= 1'b0;
            r_blnk     <= 1'b0;
            r_cell_vld <= '0;
        end else if (acc) begin
            r_row      <= n_row;
            r_col      <= n_col;
            r_addr     <= n_addr;
            r_disp     <= n_disp;
            r_curs     <= n_curs;
            r_blnk     <= n_blnk;
            r_cell_vld <= n_cell_vld;
        end
    end

    // Memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (acc && wr_en) begin
            r_mem[wr_idx] <= wr_ch;
        end
        if (acc) begin
            r_mem_q <= r_mem[rd_idx];
        end
    end

    // Stage A
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (acc) begin
            r_a_valid <= 1'b1;
        end else if (a_move) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_a_res      <= '{read_data:       rd_status,
                              row_now:         n_row,
                              col_now:         n_col,
                              display_enabled: n_disp,
                              cursor_shown:    n_curs,
                              blink_enabled:   n_blnk,
                              bad_control:     bad};
            r_a_cell     <= (i_in.op == OP_CELL) && (i_in.cell_row <= ROW_MAX)
                            && (i_in.cell_col <= COL_MAX);
            r_a_cell_vld <= r_cell_vld[rd_idx];
        end
    end

    // Merge the memory word; an unwritten cell reads as a space.
    always_comb begin
        a_merged = r_a_res;
        if (r_a_cell) begin
            a_merged.read_data = r_a_cell_vld ? r_mem_q : CHAR_SPACE;
        end
    end

    // Stage B: output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (a_move) begin
            r_b_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_b_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_move) begin
            r_b_res <= a_merged;
        end
    end

    assign o_out.valid           = r_b_valid;
    assign o_out.read_data       = r_b_res.read_data;
    assign o_out.row_now         = r_b_res.row_now;
    assign o_out.col_now         = r_b_res.col_now;
    assign o_out.display_enabled = r_b_res.display_enabled;
    assign o_out.cursor_shown    = r_b_res.cursor_shown;
    assign o_out.blink_enabled   = r_b_res.blink_enabled;
    assign o_out.bad_control     = r_b_res.bad_control;

    // Cursor column never leaves the grid.
    `CLCE_ASSERT_IMPL(a_col_in_range, i_clk, i_rst_n, 1'b1, r_col <= COL_MAX)
    // Both stages full and output stalled: input must be held off.
    `CLCE_ASSERT_IMPL(a_full_stall, i_clk, i_rst_n,
        r_a_valid && r_b_valid && !o_out.ready, !i_in.ready)
    // A clear command drops every cell back to a space.
    `CLCE_ASSERT_NEXT(a_clear_all, i_clk, i_rst_n,
        acc && i_in.op == OP_WRITE && i_in.pair_ctl == CTL_CMD
            && i_in.pair_arg == CMD_CLEAR,
        r_cell_vld == '0 && r_row == 2'd0 && r_col == 5'd0)
    // An unknown control byte leaves the cursor and address alone.
    `CLCE_ASSERT_NEXT(a_bad_ctl_hold, i_clk, i_rst_n,
        acc && i_in.op == OP_WRITE && i_in.pair_ctl != CTL_CMD
            && i_in.pair_ctl != CTL_DATA,
        $stable(r_row) && $stable(r_col) && $stable(r_addr))

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps

// Self-checking bench for the 20x4 character display controller.
// Drive a queue of items into the input channel and predict each result
// from a shadow copy of the screen, the cursor and the display flags.
// Check every output transfer in order against the predictions.
module testbench;
    import clce_pkg::*;

    // Op code with no function: the block answers with zero read data
    localparam logic [1:0] OP_NOP = 2'd3;

    // Run control
    localparam int CYCLE_LIMIT  = 200000;
    localparam int RESET_CYCLES = 12;
    localparam int IDLE_PCT     = 16;
    localparam int RANDOM_ITEMS = 1420;
    localparam int DRAIN_CYCLES = 20;
    // Window with no idling on either side
    localparam int QUIET_FROM   = 900;
    localparam int QUIET_TO     = 1200;
    // Long receiver hold-off, started after this many input transfers
    localparam int HOLD_AFTER   = 400;
    localparam int HOLD_CYCLES  = 150;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] ctl;
        logic [7:0] dat;
        logic [1:0] row;
        logic [4:0] col;
    } t_lcd_item;

    logic i_clk;
    logic i_rst_n;

    clce_in_if  lcd_in ();
    clce_out_if lcd_out ();

    char_lcd_controller_emulator DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (lcd_in),
        .o_out   (lcd_out)
    );

    // Items waiting to be offered, and results waiting to come out
    t_lcd_item lcd_items [$];
    t_res      lcd_results_due [$];

    // Shadow state of the display
    logic [6:0] shadow_cells [CELLS];
    logic [6:0] shadow_addr;
    logic [1:0] shadow_row;
    logic [4:0] shadow_col;
    logic       shadow_disp;
    logic       shadow_cursor;
    logic       shadow_blink;

    int  cyc;
    bit  in_taken;
    int  n_in;
    int  n_out;
    int  n_mismatch;
    int  n_chars;
    int  n_cmds;
    int  n_status;
    int  n_cellreads;
    int  n_ignored;
    int  hold_left;
    bit  hold_done;
    bit  quiet;

    // Clock: 10 ns period
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Advance the shadow state by one item and return the result it causes
    function automatic t_res lcd_apply_item(t_lcd_item it);
        t_res       res;
        logic [6:0] ch;
        logic [1:0] arow;
        logic [4:0] acol;
        res = '0;
        case (it.op)
            OP_WRITE: begin
                if (it.ctl == CTL_CMD) begin
                    n_cmds++;
                    if (it.dat == CMD_CLEAR) begin
                        foreach (shadow_cells[i]) shadow_cells[i] = CHAR_SPACE;
                        shadow_row  = '0;
                        shadow_col  = '0;
                        shadow_addr = '0;
                    end else if (it.dat == CMD_HOME) begin
                        shadow_row  = '0;
                        shadow_col  = '0;
                        shadow_addr = '0;
                    end else if (it.dat[7]) begin
                        // Address keeps the raw value; the cursor is clamped
                        shadow_addr = it.dat[6:0];
                        arow        = it.dat[6:5];
                        acol        = it.dat[4:0];
                        shadow_row  = (arow > ROW_MAX) ? ROW_MAX : arow;
                        shadow_col  = (acol > COL_MAX) ? COL_MAX : acol;
                    end else if ((it.dat & CMD_CTRL_MASK) == CMD_CTRL_VAL) begin
                        shadow_disp   = it.dat[2];
                        shadow_cursor = it.dat[1];
                        shadow_blink  = it.dat[0];
                    end
                end else if (it.ctl == CTL_DATA) begin
                    n_chars++;
                    ch = (it.dat >= CHAR_MIN && it.dat <= CHAR_MAX) ? it.dat[6:0]
                                                                    : CHAR_SPACE;
                    shadow_cells[int'(shadow_row) * COLS + int'(shadow_col)] = ch;
                    if (shadow_col == COL_MAX) begin
                        shadow_col = '0;
                        shadow_row = (shadow_row == ROW_MAX) ? 2'd0 : shadow_row + 2'd1;
                    end else begin
                        shadow_col = shadow_col + 5'd1;
                    end
                    shadow_addr = {shadow_row, shadow_col};
                end else begin
                    res.bad_control = 1'b1;
                end
            end
            OP_STATUS: begin
                n_status++;
                res.read_data = shadow_addr;
            end
            OP_CELL: begin
                n_cellreads++;
                if (it.row <= ROW_MAX && it.col <= COL_MAX)
                    res.read_data = shadow_cells[int'(it.row) * COLS + int'(it.col)];
            end
            default: ;
        endcase
        res.row_now         = shadow_row;
        res.col_now         = shadow_col;
        res.display_enabled = shadow_disp;
        res.cursor_shown    = shadow_cursor;
        res.blink_enabled   = shadow_blink;
        return res;
    endfunction

    // True for items that change state or read something back
    function automatic bit lcd_item_has_effect(t_lcd_item it);
        if (it.op == OP_STATUS || it.op == OP_CELL) return 1'b1;
        if (it.op != OP_WRITE) return 1'b0;
        if (it.ctl == CTL_DATA) return 1'b1;
        if (it.ctl != CTL_CMD) return 1'b0;
        return it.dat == CMD_CLEAR || it.dat == CMD_HOME || it.dat[7]
            || (it.dat & CMD_CTRL_MASK) == CMD_CTRL_VAL;
    endfunction

    task automatic add_item(logic [1:0] op, logic [7:0] ctl, logic [7:0] dat,
                            logic [1:0] row, logic [4:0] col);
        lcd_items.push_back('{op: op, ctl: ctl, dat: dat, row: row, col: col});
    endtask

    // Build one random item; most are well-formed pairs and reads
    function automatic t_lcd_item random_item();
        t_lcd_item it;
        int        p;
        int        k;
        it.op  = OP_WRITE;
        it.ctl = 8'($urandom_range(255));
        it.dat = 8'($urandom_range(255));
        it.row = 2'($urandom_range(3));
        it.col = 5'($urandom_range(31));
        p = $urandom_range(99);
        if (p < 60) begin
            k = $urandom_range(99);
            if (k < 10) begin
                // Broken pair: any control byte but the two known ones
                if (it.ctl == CTL_CMD || it.ctl == CTL_DATA) it.ctl = it.ctl ^ 8'h01;
            end else if (k < 35) begin
                it.ctl = CTL_CMD;
                k = $urandom_range(99);
                if (k < 2)
                    it.dat = CMD_CLEAR;
                else if (k < 8)
                    it.dat = CMD_HOME;
                else if (k < 45)
                    it.dat = {1'b1, 7'($urandom_range(127))};
                else if (k < 75)
                    it.dat = CMD_CTRL_VAL | 8'($urandom_range(7));
                // otherwise keep the random code, often an ignored one
            end else begin
                it.ctl = CTL_DATA;
                if ($urandom_range(99) < 85)
                    it.dat = 8'($urandom_range(CHAR_MAX, CHAR_MIN));
            end
        end else if (p < 72) begin
            it.op = OP_STATUS;
        end else if (p < 94) begin
            it.op = OP_CELL;
            if ($urandom_range(99) < 85) it.col = 5'($urandom_range(COLS - 1));
        end else begin
            it.op = OP_NOP;
        end
        return it;
    endfunction

    // Reset, then fill the item queue, wait for the drain and report
    initial begin
        i_rst_n = 1'b0;
        lcd_in.valid    = 1'b0;
        lcd_in.op       = OP_WRITE;
        lcd_in.pair_ctl = '0;
        lcd_in.pair_arg = '0;
        lcd_in.cell_row = '0;
        lcd_in.cell_col = '0;
        lcd_out.ready   = 1'b1;

        foreach (shadow_cells[i]) shadow_cells[i] = CHAR_SPACE;
        shadow_addr   = '0;
        shadow_row    = '0;
        shadow_col    = '0;
        shadow_disp   = 1'b1;
        shadow_cursor = 1'b0;
        shadow_blink  = 1'b0;

        // Directed part: reset contents, edges of the fields, every command
        add_item(OP_STATUS, 8'h00, 8'h00, 2'd0, 5'd0);
        add_item(OP_CELL,   8'h00, 8'h00, 2'd0, 5'd0);
        add_item(OP_CELL,   8'hFF, 8'hFF, ROW_MAX, COL_MAX);
        add_item(OP_CELL,   8'h00, 8'h00, 2'd0, 5'd31);       // column out of range
        add_item(OP_NOP,    8'hFF, 8'hFF, 2'd3, 5'd31);
        add_item(OP_WRITE,  8'h00, 8'h41, 2'd0, 5'd0);        // unknown control
        add_item(OP_WRITE,  8'hFF, 8'h41, 2'd3, 5'd31);
        add_item(OP_WRITE,  CTL_DATA, 8'h00, 2'd0, 5'd0);     // unprintable
        add_item(OP_WRITE,  CTL_DATA, CHAR_MIN, 2'd0, 5'd0);
        add_item(OP_WRITE,  CTL_DATA, CHAR_MAX, 2'd0, 5'd0);
        add_item(OP_WRITE,  CTL_DATA, 8'h7F, 2'd0, 5'd0);
        add_item(OP_WRITE,  CTL_DATA, 8'hFF, 2'd0, 5'd0);
        add_item(OP_WRITE,  CTL_CMD, 8'hFF, 2'd0, 5'd0);      // column clamps
        add_item(OP_STATUS, 8'h00, 8'h00, 2'd0, 5'd0);
        add_item(OP_WRITE,  CTL_DATA, 8'h41, 2'd0, 5'd0);     // wrap to top
        add_item(OP_WRITE,  CTL_CMD, 8'h93, 2'd0, 5'd0);
        add_item(OP_WRITE,  CTL_DATA, 8'h7A, 2'd0, 5'd0);     // wrap to next row
        add_item(OP_CELL,   8'h00, 8'h00, 2'd0, COL_MAX);
        add_item(OP_WRITE,  CTL_CMD, CMD_CTRL_VAL, 2'd0, 5'd0);
        add_item(OP_WRITE,  CTL_CMD, CMD_CTRL_VAL | 8'h07, 2'd0, 5'd0);
        add_item(OP_WRITE,  CTL_CMD, 8'h00, 2'd0, 5'd0);      // ignored codes
        add_item(OP_WRITE,  CTL_CMD, 8'h10, 2'd0, 5'd0);
        add_item(OP_WRITE,  CTL_CMD, 8'h7F, 2'd0, 5'd0);
        add_item(OP_WRITE,  CTL_CMD, CMD_HOME, 2'd0, 5'd0);
        add_item(OP_WRITE,  CTL_CMD, CMD_CLEAR, 2'd0, 5'd0);
        add_item(OP_CELL,   8'h00, 8'h00, ROW_MAX, COL_MAX);
        add_item(OP_WRITE,  CTL_CMD, CMD_CTRL_VAL | 8'h04, 2'd0, 5'd0);

        // Random part
        repeat (RANDOM_ITEMS) lcd_items.push_back(random_item());

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every item to go in and every result to come out
        do @(posedge i_clk);
        while (lcd_items.size() != 0 || lcd_in.valid || lcd_results_due.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d transfers in, %0d out: %0d characters, %0d commands,",
                 n_in, n_out, n_chars, n_cmds);
        $display("  %0d status reads, %0d cell reads, %0d without effect, %0d mismatches.",
                 n_status, n_cellreads, n_ignored, n_mismatch);
        if (n_mismatch == 0 && lcd_results_due.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Cycle count, quiet window and timeout
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cyc);
            $display("Some tests failed");
            $finish;
        end
    end

    initial cyc = 0;

    always @(negedge i_clk) begin
        quiet = (cyc >= QUIET_FROM && cyc < QUIET_TO);
    end

    // Sender: hold an item until its transfer, then offer the next one or idle
    always @(negedge i_clk) begin
        t_lcd_item it;
        if (!i_rst_n) begin
            lcd_in.valid <= 1'b0;
        end else if (!lcd_in.valid || in_taken) begin
            if (lcd_items.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
                it = lcd_items.pop_front();
                lcd_in.op       <= it.op;
                lcd_in.pair_ctl <= it.ctl;
                lcd_in.pair_arg <= it.dat;
                lcd_in.cell_row <= it.row;
                lcd_in.cell_col <= it.col;
                lcd_in.valid    <= 1'b1;
            end else begin
                lcd_in.valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off so the block backs up
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            lcd_out.ready <= 1'b0;
        end else if (!hold_done && n_in >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            lcd_out.ready <= 1'b0;
        end else begin
            lcd_out.ready <= quiet || $urandom_range(99) >= IDLE_PCT;
        end
    end

    initial begin
        hold_left = 0;
        hold_done = 1'b0;
        quiet     = 1'b0;
    end

    // Monitor: predict on each input transfer, check each output transfer
    always @(posedge i_clk) begin
        t_lcd_item it;
        t_res      got;
        t_res      want;
        bit        wrong;
        in_taken = 1'b0;
        if (i_rst_n) begin
            in_taken = lcd_in.valid && lcd_in.ready;
            if (in_taken) begin
                it = '{op: lcd_in.op, ctl: lcd_in.pair_ctl, dat: lcd_in.pair_arg,
                       row: lcd_in.cell_row, col: lcd_in.cell_col};
                if (!lcd_item_has_effect(it)) n_ignored++;
                lcd_results_due.push_back(lcd_apply_item(it));
                n_in++;
            end
            if (lcd_out.valid && lcd_out.ready) begin
                n_out++;
                got.read_data       = lcd_out.read_data;
                got.row_now         = lcd_out.row_now;
                got.col_now         = lcd_out.col_now;
                got.display_enabled = lcd_out.display_enabled;
                got.cursor_shown    = lcd_out.cursor_shown;
                got.blink_enabled   = lcd_out.blink_enabled;
                got.bad_control     = lcd_out.bad_control;
                if (lcd_results_due.size() == 0) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("ERROR cycle %0d: result with nothing pending", cyc);
                end else begin
                    want  = lcd_results_due.pop_front();
                    wrong = (got.read_data       !== want.read_data)
                         || (got.row_now         !== want.row_now)
                         || (got.col_now         !== want.col_now)
                         || (got.display_enabled !== want.display_enabled)
                         || (got.cursor_shown    !== want.cursor_shown)
                         || (got.blink_enabled   !== want.blink_enabled)
                         || (got.bad_control     !== want.bad_control);
                    if (wrong) begin
                        n_mismatch++;
                        if (n_mismatch <= 10) begin
                            $display("ERROR result %0d: want rd=%h r=%0d c=%0d d/c/b=%b%b%b bad=%b",
                                     n_out, want.read_data, want.row_now, want.col_now,
                                     want.display_enabled, want.cursor_shown,
                                     want.blink_enabled, want.bad_control);
                            $display("      got rd=%h r=%0d c=%0d d/c/b=%b%b%b bad=%b",
                                     got.read_data, got.row_now, got.col_now,
                                     got.display_enabled, got.cursor_shown,
                                     got.blink_enabled, got.bad_control);
                        end
                    end
                end
            end
        end
    end

    initial begin
        n_in        = 0;
        n_out       = 0;
        n_mismatch  = 0;
        n_chars     = 0;
        n_cmds      = 0;
        n_status    = 0;
        n_cellreads = 0;
        n_ignored   = 0;
        in_taken    = 1'b0;
    end

endmodule
